// ===== sv/ryr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ryr_pkg
// Shared types, constants and the arctangent table for the yaw/roll block.
// ----------------------------------------------------------------------------
package ryr_pkg;

    // Iteration count of the CORDIC (8 to 24)
    localparam int CORDIC_STEPS = 16;
    localparam int CNT_W        = $clog2(CORDIC_STEPS);
    localparam int TAB_IDX_W    = 5;

    // Field and datapath widths
    localparam int COEF_W  = 16;
    localparam int ANGLE_W = 16;
    localparam int XY_W    = 28;
    localparam int Z_W     = 25;
    localparam int JUMP_W  = 16;
    localparam int TOL_W   = 15;

    localparam logic signed [Z_W-1:0]     QUARTER_TURN = Z_W'(2949120);
    localparam logic signed [ANGLE_W:0]   ANGLE_MAX    = (ANGLE_W+1)'(23040);
    localparam logic [JUMP_W-1:0]         JUMP_RST     = JUMP_W'(6400);
    localparam logic [TOL_W-1:0]          TOL_RST      = TOL_W'(3200);

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_JUMP_LIMIT = 1'b0,
        CFG_MAG_TOL    = 1'b1
    } t_cfg_idx;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ITER,
        ST_ROUND,
        ST_FIX
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic                 load;
        logic                 step;
        logic                 round;
        logic                 fix;
        logic [TAB_IDX_W-1:0] idx;
    } t_dp_cmd;

    // atan(2^-i) in units of 2^-15 degree
    function automatic logic [Z_W-1:0] atan_entry(input logic [TAB_IDX_W-1:0] idx);
        logic [Z_W-1:0] v;
        case (idx)
            5'd0:    v = Z_W'(1474560);
            5'd1:    v = Z_W'(870484);
            5'd2:    v = Z_W'(459940);
            5'd3:    v = Z_W'(233473);
            5'd4:    v = Z_W'(117189);
            5'd5:    v = Z_W'(58652);
            5'd6:    v = Z_W'(29333);
            5'd7:    v = Z_W'(14667);
            5'd8:    v = Z_W'(7334);
            5'd9:    v = Z_W'(3667);
            5'd10:   v = Z_W'(1833);
            5'd11:   v = Z_W'(917);
            5'd12:   v = Z_W'(458);
            5'd13:   v = Z_W'(229);
            5'd14:   v = Z_W'(115);
            5'd15:   v = Z_W'(57);
            5'd16:   v = Z_W'(29);
            5'd17:   v = Z_W'(14);
            5'd18:   v = Z_W'(7);
            5'd19:   v = Z_W'(4);
            5'd20:   v = Z_W'(2);
            5'd21:   v = Z_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/ryr_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ryr_cordic
// One vectoring CORDIC lane: atan2(y, x) in 1/128 degree, one step a cycle.
// ----------------------------------------------------------------------------
module ryr_cordic (
    input  logic                                 i_clk,
    input  ryr_pkg::t_dp_cmd                     i_cmd,
    input  logic signed [ryr_pkg::COEF_W-1:0]    i_y,
    input  logic signed [ryr_pkg::COEF_W-1:0]    i_x,
    output logic signed [ryr_pkg::ANGLE_W-1:0]   o_angle
);

    logic signed [ryr_pkg::XY_W-1:0]    r_x, r_y;
    logic signed [ryr_pkg::Z_W-1:0]     r_z;
    logic                               r_zero;
    logic signed [ryr_pkg::ANGLE_W-1:0] r_q;

    logic signed [ryr_pkg::XY_W-1:0]    x_ext, y_ext, dx, dy;
    logic signed [ryr_pkg::Z_W-1:0]     a_step, z_bias;
    logic signed [ryr_pkg::ANGLE_W:0]   q_wide, q_sat;

    // Scale operands by 256
    assign x_ext = ryr_pkg::XY_W'(i_x) <<< 8;
    assign y_ext = ryr_pkg::XY_W'(i_y) <<< 8;

    // Floor shifts and table angle for this step
    assign dx     = r_y >>> i_cmd.idx;
    assign dy     = r_x >>> i_cmd.idx;
    assign a_step = $signed(ryr_pkg::atan_entry(i_cmd.idx));

    // Round to 1/128 degree and saturate
    assign z_bias = r_z + ryr_pkg::Z_W'(128);
    assign q_wide = (ryr_pkg::ANGLE_W+1)'(z_bias >>> 8);
    always_comb begin
        if (q_wide > ryr_pkg::ANGLE_MAX) begin
            q_sat = ryr_pkg::ANGLE_MAX;
        end else if (q_wide < -ryr_pkg::ANGLE_MAX) begin
            q_sat = -ryr_pkg::ANGLE_MAX;
        end else begin
            q_sat = q_wide;
        end
    end

    // Load, with a quarter-turn pre-rotation when x is negative, then iterate and round
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_zero <= (i_x == '0) && (i_y == '0);
            if (x_ext < 0) begin
                if (y_ext >= 0) begin
                    r_x <= y_ext;
                    r_y <= -x_ext;
                    r_z <= ryr_pkg::QUARTER_TURN;
                end else begin
                    r_x <= -y_ext;
                    r_y <= x_ext;
                    r_z <= -ryr_pkg::QUARTER_TURN;
                end
            end else begin
                r_x <= x_ext;
                r_y <= y_ext;
                r_z <= '0;
            end
        end else if (i_cmd.step) begin
            if (r_y > 0) begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + a_step;
            end else begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - a_step;
            end
        end
        if (i_cmd.round) begin
            r_q <= r_zero ? '0 : ryr_pkg::ANGLE_W'(q_sat);
        end
    end

    assign o_angle = r_q;

endmodule

// ===== sv/ryr_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ryr_dp
// Datapath: yaw and roll CORDIC lanes, jump correction, history and output.
// ----------------------------------------------------------------------------
module ryr_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  ryr_pkg::t_dp_cmd                     i_cmd,
    input  logic signed [ryr_pkg::COEF_W-1:0]    i_r00,
    input  logic signed [ryr_pkg::COEF_W-1:0]    i_r10,
    input  logic signed [ryr_pkg::COEF_W-1:0]    i_r21,
    input  logic signed [ryr_pkg::COEF_W-1:0]    i_r22,
    input  logic [ryr_pkg::JUMP_W-1:0]           i_jump_limit,
    input  logic [ryr_pkg::TOL_W-1:0]            i_mag_tol,
    output logic signed [ryr_pkg::ANGLE_W-1:0]   o_yaw,
    output logic signed [ryr_pkg::ANGLE_W-1:0]   o_roll
);

    localparam int AW = ryr_pkg::ANGLE_W;

    logic signed [AW-1:0] yaw, roll;
    logic signed [AW-1:0] r_prev_yaw, r_prev_roll, r_yaw_out, r_roll_out;
    logic                 r_seen;

    logic signed [AW:0]   yaw_d, roll_d, mag_d;
    logic [AW:0]          yaw_d_abs, roll_d_abs, mag_d_abs;
    logic [AW-1:0]        yaw_abs, prev_yaw_abs;
    logic                 yaw_flip, roll_flip, roll_opp;
    logic signed [AW-1:0] yaw_fix, roll_fix;

    ryr_cordic u_yaw (
        .i_clk   (i_clk),
        .i_cmd   (i_cmd),
        .i_y     (i_r10),
        .i_x     (i_r00),
        .o_angle (yaw)
    );

    ryr_cordic u_roll (
        .i_clk   (i_clk),
        .i_cmd   (i_cmd),
        .i_y     (i_r21),
        .i_x     (i_r22),
        .o_angle (roll)
    );

    // Yaw jump test: large step but similar magnitude
    assign yaw_d        = (AW+1)'(yaw) - (AW+1)'(r_prev_yaw);
    assign yaw_d_abs    = yaw_d[AW] ? (AW+1)'(-yaw_d) : (AW+1)'(yaw_d);
    assign yaw_abs      = yaw[AW-1] ? AW'(-yaw) : AW'(yaw);
    assign prev_yaw_abs = r_prev_yaw[AW-1] ? AW'(-r_prev_yaw) : AW'(r_prev_yaw);
    assign mag_d        = $signed({1'b0, yaw_abs}) - $signed({1'b0, prev_yaw_abs});
    assign mag_d_abs    = mag_d[AW] ? (AW+1)'(-mag_d) : (AW+1)'(mag_d);
    assign yaw_flip     = r_seen
                        && (yaw_d_abs > (AW+1)'(i_jump_limit))
                        && (mag_d_abs < (AW+1)'(i_mag_tol));

    // Roll jump test: strict sign reversal with a large step
    assign roll_d     = (AW+1)'(roll) - (AW+1)'(r_prev_roll);
    assign roll_d_abs = roll_d[AW] ? (AW+1)'(-roll_d) : (AW+1)'(roll_d);
    assign roll_opp   = ((roll > 0) && (r_prev_roll < 0))
                     || ((roll < 0) && (r_prev_roll > 0));
    assign roll_flip  = r_seen && roll_opp && (roll_d_abs > (AW+1)'(i_jump_limit));

    assign yaw_fix  = yaw_flip  ? -yaw  : yaw;
    assign roll_fix = roll_flip ? -roll : roll;

    // History flag and previous corrected angles
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen      <= 1'b0;
            r_prev_yaw  <= '0;
            r_prev_roll <= '0;
        end else if (i_cmd.fix) begin
            r_seen      <= 1'b1;
            r_prev_yaw  <= yaw_fix;
            r_prev_roll <= roll_fix;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.fix) begin
            r_yaw_out  <= yaw_fix;
            r_roll_out <= roll_fix;
        end
    end

    assign o_yaw  = r_yaw_out;
    assign o_roll = r_roll_out;

endmodule

// ===== sv/ryr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ryr_ctrl
// Controller: sequences load, CORDIC steps, rounding and correction per beat.
// ----------------------------------------------------------------------------
module ryr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output ryr_pkg::t_dp_cmd  o_cmd
);

    ryr_pkg::t_state             r_state, n_state;
    logic [ryr_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic                        r_out_vld, n_out_vld;
    logic                        last_step, out_free;

    assign last_step = (r_cnt == ryr_pkg::CNT_W'(ryr_pkg::CORDIC_STEPS - 1));
    assign out_free  = !r_out_vld || i_out_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ryr_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ryr_pkg::ST_ITER;
                end
            end
            ryr_pkg::ST_ITER: begin
                if (last_step) begin
                    n_state = ryr_pkg::ST_ROUND;
                end
            end
            ryr_pkg::ST_ROUND: begin
                n_state = ryr_pkg::ST_FIX;
            end
            ryr_pkg::ST_FIX: begin
                if (out_free) begin
                    n_state = ryr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ryr_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and commands
    always_comb begin
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        o_cmd.idx   = ryr_pkg::TAB_IDX_W'(r_cnt);
        n_cnt       = '0;
        n_out_vld   = r_out_vld && !i_out_ready;
        case (r_state)
            ryr_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ryr_pkg::ST_ITER: begin
                o_cmd.step = 1'b1;
                n_cnt      = last_step ? '0 : r_cnt + 1'b1;
            end
            ryr_pkg::ST_ROUND: begin
                o_cmd.round = 1'b1;
            end
            ryr_pkg::ST_FIX: begin
                o_cmd.fix = out_free;
                if (out_free) begin
                    n_out_vld = 1'b1;
                end
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ryr_pkg::ST_IDLE;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_out_valid = r_out_vld;

endmodule

// ===== sv/rotation_to_yaw_roll_with_jump_fix.sv =====
`timescale 1ns / 1ps
// An accepted input beat is loaded into both CORDIC lanes, iterated CORDIC_STEPS (16)
//   times, rounded, then jump-corrected into the output register; input ready is
//   high only in idle, so a new beat waits until the last one has been corrected.
// A finished result waits in the output register; a new input beat is taken meanwhile.
// Reset (synchronous, active low) clears the history and restores both limits.
// ----------------------------------------------------------------------------
// rotation_to_yaw_roll_with_jump_fix
// Yaw and roll from rotation matrix entries via CORDIC, with jump correction.
// ----------------------------------------------------------------------------
module rotation_to_yaw_roll_with_jump_fix (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,   // r00 [15:0], r10 [31:16], r21 [47:32], r22 [63:48]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [31:0]  m_axis_tdata,   // yaw_angle [15:0], roll_angle [31:16]
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [0:0]   i_cfg_index,
    input  logic [15:0]  i_cfg_data
);

    logic [ryr_pkg::JUMP_W-1:0]          r_jump_limit;
    logic [ryr_pkg::TOL_W-1:0]           r_mag_tol;
    ryr_pkg::t_dp_cmd                    cmd;
    logic signed [ryr_pkg::ANGLE_W-1:0]  yaw, roll;

    // Configuration registers, always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jump_limit <= ryr_pkg::JUMP_RST;
            r_mag_tol    <= ryr_pkg::TOL_RST;
        end else if (i_cfg_valid) begin
            case (ryr_pkg::t_cfg_idx'(i_cfg_index))
                ryr_pkg::CFG_JUMP_LIMIT: r_jump_limit <= i_cfg_data;
                ryr_pkg::CFG_MAG_TOL:    r_mag_tol    <= i_cfg_data[ryr_pkg::TOL_W-1:0];
                default:                 r_jump_limit <= r_jump_limit;
            endcase
        end
    end

    ryr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (cmd)
    );

    ryr_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_r00        ($signed(s_axis_tdata[15:0])),
        .i_r10        ($signed(s_axis_tdata[31:16])),
        .i_r21        ($signed(s_axis_tdata[47:32])),
        .i_r22        ($signed(s_axis_tdata[63:48])),
        .i_jump_limit (r_jump_limit),
        .i_mag_tol    (r_mag_tol),
        .o_yaw        (yaw),
        .o_roll       (roll)
    );

    assign m_axis_tdata = {roll, yaw};

`ifndef SYNTHESIS
    // An accepted beat starts work, so the input side closes the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready stayed high after an accepted beat");

    // Output angles stay within the saturation range
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[15:0]) <= 16'sd23040
                       && $signed(m_axis_tdata[15:0]) >= -16'sd23040
                       && $signed(m_axis_tdata[31:16]) <= 16'sd23040
                       && $signed(m_axis_tdata[31:16]) >= -16'sd23040))
        else $error("output angle out of range");

    // No output beat is pending right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");
`endif

endmodule

// ===== tb/rotation_to_yaw_roll_with_jump_fix_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_to_yaw_roll_with_jump_fix_test
// Drives rotation-matrix beats into the yaw/roll block. A scoreboard class
// recomputes both CORDIC angles and the jump correction for every accepted
// beat. Each output beat is compared field by field. Runs cover several
// limit settings, random idling on both ports and one long output stall.
// ----------------------------------------------------------------------------
module rotation_to_yaw_roll_with_jump_fix_test;

    localparam int  JUMP_LIMIT_RST = 6400;
    localparam int  MAG_TOL_RST    = 3200;
    localparam int  RIGHT_ANGLE_Z  = 2949120;  // 90 degrees in 2^-15 degree
    localparam int  ANGLE_LIMIT    = 23040;
    localparam int  ATAN_LEN       = 24;
    localparam int  SETTLE_CYCLES  = 24;
    localparam int  LONG_HOLD      = 300;
    localparam int  HOLD_AFTER     = 150;
    localparam int  WATCHDOG_LIMIT = 4000;
    localparam real DEG_TO_RAD     = 3.14159265358979 / 180.0;

    // atan(2^-i) in 2^-15 degree units
    localparam int ATAN_STEP [ATAN_LEN] = '{
        1474560, 870484, 459940, 233473, 117189, 58652, 29333, 14667,
        7334, 3667, 1833, 917, 458, 229, 115, 57,
        29, 14, 7, 4, 2, 1, 0, 0
    };

    typedef struct {
        logic signed [15:0] yaw;
        logic signed [15:0] roll;
    } t_angle_pair;

    // Angle predictor with jump correction and a queue of pending angle pairs
    class yaw_roll_scoreboard;
        int          jump_limit;
        int          mag_tol;
        bit          seen_first;
        int          prev_yaw;
        int          prev_roll;
        t_angle_pair pending[$];
        int unsigned mismatches;
        int unsigned results_seen;

        function new();
            jump_limit   = JUMP_LIMIT_RST;
            mag_tol      = MAG_TOL_RST;
            seen_first   = 1'b0;
            prev_yaw     = 0;
            prev_roll    = 0;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void write_reg(ryr_pkg::t_cfg_idx idx, logic [15:0] value);
            case (idx)
                ryr_pkg::CFG_JUMP_LIMIT: jump_limit = int'(value);
                ryr_pkg::CFG_MAG_TOL:    mag_tol = int'(value[14:0]);
                default: ;
            endcase
        endfunction

        function int magnitude(int v);
            return (v < 0) ? -v : v;
        endfunction

        // Vectoring CORDIC, result in 1/128 degree
        function int cordic_angle(int yin, int xin);
            int x;
            int y;
            int z;
            int dx;
            int dy;
            int swap;
            int rounded;
            if (xin == 0 && yin == 0)
                return 0;
            x = xin * 256;
            y = yin * 256;
            z = 0;
            // fold the left half plane onto the right one
            if (x < 0) begin
                swap = x;
                if (y >= 0) begin
                    x = y;
                    y = -swap;
                    z = RIGHT_ANGLE_Z;
                end else begin
                    x = -y;
                    y = swap;
                    z = -RIGHT_ANGLE_Z;
                end
            end
            for (int i = 0; i < ryr_pkg::CORDIC_STEPS && i < ATAN_LEN; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y > 0) begin
                    x = x + dx;
                    y = y - dy;
                    z = z + ATAN_STEP[i];
                end else begin
                    x = x - dx;
                    y = y + dy;
                    z = z - ATAN_STEP[i];
                end
            end
            rounded = (z + 128) >>> 8;
            if (rounded > ANGLE_LIMIT)
                rounded = ANGLE_LIMIT;
            else if (rounded < -ANGLE_LIMIT)
                rounded = -ANGLE_LIMIT;
            return rounded;
        endfunction

        function void note_input(logic [63:0] beat);
            int          yaw;
            int          roll;
            t_angle_pair due;
            yaw  = cordic_angle(int'($signed(beat[31:16])), int'($signed(beat[15:0])));
            roll = cordic_angle(int'($signed(beat[47:32])), int'($signed(beat[63:48])));
            // undo suspected sign flips against the stored angles
            if (seen_first) begin
                if (magnitude(yaw - prev_yaw) > jump_limit &&
                    magnitude(magnitude(yaw) - magnitude(prev_yaw)) < mag_tol)
                    yaw = -yaw;
                if (((roll > 0 && prev_roll < 0) || (roll < 0 && prev_roll > 0)) &&
                    magnitude(roll - prev_roll) > jump_limit)
                    roll = -roll;
            end
            seen_first = 1'b1;
            prev_yaw   = yaw;
            prev_roll  = roll;
            due.yaw    = 16'(yaw);
            due.roll   = 16'(roll);
            pending.push_back(due);
        endfunction

        function void check_result(logic [31:0] beat);
            t_angle_pair due;
            results_seen++;
            if (pending.size() == 0) begin
                $error("unexpected result beat %h", beat);
                mismatches++;
                return;
            end
            due = pending.pop_front();
            if (beat[15:0] !== due.yaw) begin
                $error("yaw_angle: expected %0d, got %0d", due.yaw, $signed(beat[15:0]));
                mismatches++;
            end
            if (beat[31:16] !== due.roll) begin
                $error("roll_angle: expected %0d, got %0d", due.roll, $signed(beat[31:16]));
                mismatches++;
            end
        endfunction
    endclass

    bit          i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // r00 [15:0], r10 [31:16], r21 [47:32], r22 [63:48]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // yaw_angle [15:0], roll_angle [31:16]
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [0:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    yaw_roll_scoreboard angles_sb;
    int                 idle_cycles;
    bit                 no_idle;
    real                yaw_deg;
    real                roll_deg;

    rotation_to_yaw_roll_with_jump_fix DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Free-running clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Sample every handshake at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                angles_sb.check_result(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                angles_sb.note_input(s_axis_tdata);
            if (i_cfg_valid && o_cfg_ready)
                angles_sb.write_reg(ryr_pkg::t_cfg_idx'(i_cfg_index), i_cfg_data);
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) ||
                (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
        end
    end

    // Stop the run when nothing moves for too long
    initial begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
            @(negedge i_clk);
        $display("rotation_to_yaw_roll_with_jump_fix_test: FAIL");
        $finish;
    end

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int draw;
        if (no_idle)
            return 0;
        draw = $urandom_range(0, 99);
        if (draw < 60)
            return 0;
        if (draw < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Output side: random stalls, one long hold once enough results passed
    initial begin
        int gap;
        bit long_hold_done;
        m_axis_tready  = 1'b0;
        long_hold_done = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            gap = pick_gap();
            if (!long_hold_done && angles_sb.results_seen >= HOLD_AFTER) begin
                gap            = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            if (gap > 0) begin
                m_axis_tready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid)
                @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    // Offer one beat after a random gap; return at the falling edge after acceptance
    task automatic send_beat(logic [63:0] beat);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = beat;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_coeffs(int r00, int r10, int r21, int r22);
        send_beat({16'(r22), 16'(r21), 16'(r10), 16'(r00)});
    endtask

    task automatic cfg_write(ryr_pkg::t_cfg_idx idx, int value);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = 16'(value);
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Hold input until every pending result is out, then let the block settle
    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (angles_sb.pending.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic int corner_value();
        case ($urandom_range(0, 6))
            0:       return -32768;
            1:       return -16384;
            2:       return -1;
            3:       return 0;
            4:       return 1;
            5:       return 16384;
            default: return 32767;
        endcase
    endfunction

    // Advance the pose: small steps, wraps near 180, sign flips, sudden moves
    task automatic step_pose();
        case ($urandom_range(0, 24))
            0:       yaw_deg = -yaw_deg;
            1:       roll_deg = -roll_deg;
            2:       yaw_deg = $urandom_range(0, 3600) / 10.0 - 180.0;
            3:       roll_deg = $urandom_range(0, 3600) / 10.0 - 180.0;
            4:       yaw_deg = 172.0 + $urandom_range(0, 800) / 100.0;
            5:       roll_deg = -172.0 - $urandom_range(0, 800) / 100.0;
            default: begin
                yaw_deg  = yaw_deg + $urandom_range(0, 1600) / 100.0 - 8.0;
                roll_deg = roll_deg + $urandom_range(0, 1600) / 100.0 - 8.0;
            end
        endcase
        while (yaw_deg > 180.0)   yaw_deg = yaw_deg - 360.0;
        while (yaw_deg < -180.0)  yaw_deg = yaw_deg + 360.0;
        while (roll_deg > 180.0)  roll_deg = roll_deg - 360.0;
        while (roll_deg < -180.0) roll_deg = roll_deg + 360.0;
    endtask

    function automatic logic [63:0] pose_beat();
        real scale_y;
        real scale_r;
        int  r00;
        int  r10;
        int  r21;
        int  r22;
        scale_y = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 100) / 100.0 : 1.0;
        scale_r = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 100) / 100.0 : 1.0;
        r00 = int'(16384.0 * scale_y * $cos(yaw_deg * DEG_TO_RAD));
        r10 = int'(16384.0 * scale_y * $sin(yaw_deg * DEG_TO_RAD));
        r21 = int'(16384.0 * scale_r * $sin(roll_deg * DEG_TO_RAD));
        r22 = int'(16384.0 * scale_r * $cos(roll_deg * DEG_TO_RAD));
        return {16'(r22), 16'(r21), 16'(r10), 16'(r00)};
    endfunction

    // Mostly smooth pose sequences, with raw noise and corner values mixed in
    task automatic run_poses(int count);
        int          draw;
        logic [63:0] beat;
        for (int n = 0; n < count; n++) begin
            draw = $urandom_range(0, 99);
            if (draw < 10) begin
                beat = {$urandom, $urandom};
            end else if (draw < 15) begin
                beat = {16'(corner_value()), 16'(corner_value()),
                        16'(corner_value()), 16'(corner_value())};
            end else begin
                step_pose();
                beat = pose_beat();
            end
            send_beat(beat);
        end
    endtask

    initial begin
        int jump_val;
        int tol_val;
        angles_sb     = new();
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = ryr_pkg::CFG_JUMP_LIMIT;
        i_cfg_data    = '0;
        no_idle       = 1'b0;
        yaw_deg       = 170.0;
        roll_deg      = -170.0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed beats under the reset limits
        send_coeffs(0, 0, 0, 0);                 // first beat, zero vectors
        send_coeffs(16384, 0, 0, 16384);
        send_coeffs(-16384, 0, 0, -16384);       // negative x, zero y
        send_coeffs(-16384, -1, -1, -16384);     // wrap past 180: both flipped back
        send_coeffs(0, 16384, 16384, 0);
        send_coeffs(0, -16384, -16384, 0);       // pure sign flips
        send_coeffs(32767, 32767, -32768, -32768);
        send_coeffs(-32768, 32767, 32767, -32768);
        send_coeffs(-32768, -32768, 0, -32768);
        send_coeffs(16384, 16384, 16384, 16384);
        send_coeffs(-16384, 16384, 16384, -16384);
        send_coeffs(0, 0, 0, 0);
        send_coeffs(1, 0, 0, 1);
        send_coeffs(-1, 0, 0, -1);
        send_coeffs(0, -1, 1, 0);
        send_coeffs(16384, -16384, -16384, 16384);
        send_coeffs(-16384, -16384, -16384, -16384);
        run_poses(60);

        // Sweep the limits, extremes first
        for (int phase = 1; phase <= 6; phase++) begin
            drain();
            case (phase)
                1: begin jump_val = 0;     tol_val = 0;     end
                2: begin jump_val = 46080; tol_val = 23040; end
                3: begin jump_val = 6400;  tol_val = 0;     end
                4: begin jump_val = 0;     tol_val = 23040; end
                default: begin
                    jump_val = $urandom_range(0, 46080);
                    tol_val  = $urandom_range(0, 23040);
                end
            endcase
            cfg_write(ryr_pkg::CFG_JUMP_LIMIT, jump_val);
            cfg_write(ryr_pkg::CFG_MAG_TOL, tol_val);
            no_idle = (phase == 2);
            run_poses(65);
        end

        drain();
        if (angles_sb.mismatches == 0 && angles_sb.pending.size() == 0)
            $display("rotation_to_yaw_roll_with_jump_fix_test: PASS");
        else
            $display("rotation_to_yaw_roll_with_jump_fix_test: FAIL");
        $finish;
    end

endmodule
